### hw/rtl/hid_keyboard_report_builder_core_defines.svh
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_core_defines.svh
// Assertion macros used by the keyboard report builder datapath.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_BUILDER_CORE_DEFINES_SVH
`define HID_KEYBOARD_REPORT_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HKRB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hkrb same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HKRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hkrb next-cycle check failed");

`endif

### hw/rtl/hkrb_pkg.sv
// ----------------------------------------------------------------------------
// hkrb_pkg
// Types and constants of the keyboard report builder.
// ----------------------------------------------------------------------------
package hkrb_pkg;

  localparam int CODE_W    = 8;
  localparam int MAP_DEPTH = 1 << CODE_W;
  localparam int NUM_SLOTS = 6;
  localparam int CNT_W     = 3;
  localparam int DIFF_W    = CODE_W + 1;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 64;

  localparam logic [CODE_W-1:0] MOD_FIRST     = 8'd224;
  localparam logic [CODE_W-1:0] KEY_FIRST     = 8'd4;
  localparam logic [CODE_W-1:0] KEY_LAST      = 8'd221;
  localparam logic [CODE_W-1:0] ROLLOVER_CODE = 8'h01;
  localparam logic [15:0]       MIN_ROOM      = 16'd8;
  localparam logic [CNT_W-1:0]  CNT_FULL      = 3'd7;

  localparam logic OP_KEY_EVENT = 1'b0;
  localparam logic OP_REPORT    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVT_RD,
    ST_EVT_WR,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic evt_rd;
    logic evt_wr;
    logic scan_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_event;
    logic in_report;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/hkrb_ram.sv
// ----------------------------------------------------------------------------
// hkrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hkrb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/hkrb_ctrl.sv
// ----------------------------------------------------------------------------
// hkrb_ctrl
// Sequencer of the keyboard report builder: clearing pass, key events,
// report scans and result hand-off.
// ----------------------------------------------------------------------------
module hkrb_ctrl
  import hkrb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          priority if (status.in_event) begin
            state_next = ST_EVT_RD;
          end else if (status.in_report) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_EVT_RD: begin
        cmd.evt_rd = 1'b1;
        state_next = ST_EVT_WR;
      end
      ST_EVT_WR: begin
        cmd.evt_wr = 1'b1;
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.idx_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

### hw/rtl/hkrb_datapath.sv
// ----------------------------------------------------------------------------
// hkrb_datapath
// Key maps, scan pipeline, report accumulators and the output word register.
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_builder_core_defines.svh"

module hkrb_datapath
  import hkrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tuser
);

  logic              report_q;
  logic [CODE_W-1:0] code_q;
  logic              down_q;

  logic [CODE_W-1:0] idx;
  logic              rd_valid;
  logic [CODE_W-1:0] rd_idx;
  logic [DIFF_W-1:0] diff_cnt;
  logic [7:0]        mods;
  logic [CODE_W-1:0] slots [NUM_SLOTS];
  logic [CNT_W-1:0]  cnt;

  logic              live_we, pend_we, rep_we;
  logic [CODE_W-1:0] live_wa, pend_wa, rep_wa;
  logic              live_wd, pend_wd, rep_wd;
  logic [CODE_W-1:0] pend_ra;
  logic              live_rd, pend_rd, rep_rd;

  logic              in_report;
  logic              is_mod, is_key;
  logic              rollover;
  logic [CODE_W-1:0] slot6;

  assign in_report = (s_tuser == OP_REPORT) && s_tdata[9] && (s_tdata[25:10] >= MIN_ROOM);

  assign status.in_event  = (s_tuser == OP_KEY_EVENT);
  assign status.in_report = in_report;
  assign status.idx_last  = (idx == CODE_W'(MAP_DEPTH - 1));
  assign status.out_free  = !m_tvalid || m_tready;

  // Map write and read port selection.
  always_comb begin
    live_we = cmd.clr_wr || cmd.evt_wr;
    live_wa = cmd.clr_wr ? idx : code_q;
    live_wd = cmd.clr_wr ? 1'b0 : down_q;

    pend_we = cmd.clr_wr || rd_valid || (cmd.evt_wr && (rep_rd != down_q));
    priority if (cmd.clr_wr) begin
      pend_wa = idx;
      pend_wd = 1'b0;
    end else if (rd_valid) begin
      pend_wa = rd_idx;
      pend_wd = live_rd;
    end else begin
      pend_wa = code_q;
      pend_wd = down_q;
    end
    pend_ra = cmd.evt_rd ? code_q : idx;

    rep_we = cmd.clr_wr || rd_valid;
    rep_wa = cmd.clr_wr ? idx : rd_idx;
    rep_wd = cmd.clr_wr ? 1'b0 : pend_rd;
  end

  hkrb_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_live (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_wa),
    .wdata (live_wd),
    .raddr (idx),
    .rdata (live_rd)
  );

  hkrb_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_pending (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_wa),
    .wdata (pend_wd),
    .raddr (pend_ra),
    .rdata (pend_rd)
  );

  hkrb_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_reported (
    .clk   (clk),
    .we    (rep_we),
    .waddr (rep_wa),
    .wdata (rep_wd),
    .raddr (code_q),
    .rdata (rep_rd)
  );

  assign is_mod = (rd_idx[CODE_W-1:3] == MOD_FIRST[CODE_W-1:3]);
  assign is_key = (rd_idx >= KEY_FIRST) && (rd_idx <= KEY_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
      diff_cnt <= '0;
    end else begin
      if (cmd.clr_wr || cmd.scan_rd) begin
        idx <= idx + 1'b1;
      end
      rd_valid <= cmd.scan_rd;
      priority if (cmd.load && in_report) begin
        diff_cnt <= '0;
      end else if (rd_valid) begin
        diff_cnt <= diff_cnt + DIFF_W'(live_rd != pend_rd);
      end else if (cmd.evt_wr) begin
        diff_cnt <= diff_cnt + DIFF_W'((rep_rd != down_q) && (pend_rd == rep_rd));
      end else begin
        diff_cnt <= diff_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (cmd.load) begin
      report_q <= in_report;
      code_q   <= s_tdata[7:0];
      down_q   <= s_tdata[8];
      mods     <= '0;
      cnt      <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (rd_valid && pend_rd) begin
      if (is_mod) begin
        mods[rd_idx[2:0]] <= 1'b1;
      end
      if (is_key && (cnt != CNT_FULL)) begin
        if (cnt < CNT_W'(NUM_SLOTS)) begin
          slots[cnt] <= rd_idx;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign rollover = (cnt == CNT_FULL);
  assign slot6    = rollover ? ROLLOVER_CODE : slots[NUM_SLOTS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= report_q;
      m_tdata <= {6'd0, (diff_cnt != '0), rollover, slot6, slots[4], slots[3],
                  slots[2], slots[1], slots[0], mods};
    end
  end

  `HKRB_ASSERT_NOW(a_diff_range, clk, rst, 1'b1, diff_cnt <= DIFF_W'(MAP_DEPTH))
  `HKRB_ASSERT_NOW(a_rollover_in_report, clk, rst, m_tvalid && m_tdata[56], m_tuser)
  `HKRB_ASSERT_NOW(a_empty_without_report, clk, rst, m_tvalid && !m_tuser,
                   m_tdata[56:0] == 57'd0)
  `HKRB_ASSERT_NEXT(a_scan_ends, clk, rst,
                    rd_valid && (rd_idx == CODE_W'(MAP_DEPTH - 1)), !rd_valid)

endmodule

### hw/rtl/hid_keyboard_report_builder_core.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_core
// USB boot keyboard report builder with live, pending and reported key maps.
// ----------------------------------------------------------------------------
// Each input word is either a key event or a report request, and each gives
// exactly one output word. After reset the three 256-entry key maps are
// cleared in a pass during which no input word is taken. A key
// event passes a map read state and a map write state. A granted report
// request scans all 256 codes of the pending map through the map RAMs, one
// code per cycle, and then passes a flush state. A refused request goes
// straight on. Each result is loaded into the output register once that
// register is free, and no new input word is taken before that. The next
// input word is taken while the previous result still waits on the
// output.
module hid_keyboard_report_builder_core
  import hkrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // [7:0] key_code, [8] key_down, [9] is_input_request, [25:10] room_bytes
  input  logic [IN_W-1:0]  s_tdata,
  // [0] op
  input  logic             s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // [7:0] modifiers, [15:8] key_slot_1 ... [55:48] key_slot_6,
  // [56] rollover, [57] report_pending
  output logic [OUT_W-1:0] m_tdata,
  // [0] report_made
  output logic             m_tuser
);

  cmd_t    cmd;
  status_t status;

  hkrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hkrb_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### test/hid_keyboard_report_builder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_core_tb
// Self-checking regression of the keyboard report builder. A directed table
// covers reset, refused requests, modifier and out-of-range codes, taps and
// rollover. Random key events and report requests then follow, with idle
// gaps and stalls on both stream sides. Every output word is compared with a
// literal row word or the word a local model of the three key maps computes.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_core_tb;
  import hkrb_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int RST_CYCLES = 8;
  localparam int N_RANDOM   = 400;
  localparam int HOLD_LONG  = 600;
  localparam int DRAIN_WAIT = 300;
  localparam int LIMIT      = 1000000;

  typedef struct packed {
    logic        op;
    logic [7:0]  code;
    logic        down;
    logic        is_in;
    logic [15:0] room;
  } kb_word_t;

  typedef struct packed {
    logic            report_pending;
    logic            rollover;
    logic [5:0][7:0] slot;
    logic [7:0]      modifiers;
    logic            report_made;
  } kb_report_t;

  typedef struct packed {
    kb_word_t   stim;
    logic       lit;
    kb_report_t want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;

  logic [MAP_DEPTH-1:0] live_keys;
  logic [MAP_DEPTH-1:0] pend_keys;
  logic [MAP_DEPTH-1:0] sent_keys;
  kb_report_t           report_q[$];
  kb_report_t           seen_word;
  kb_report_t           want_word;
  int                   mismatch_count;
  int                   cycle_count;
  int                   stall_left;
  bit                   long_hold_req;
  bit                   rx_quiet;

  hid_keyboard_report_builder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic predict_report(input kb_word_t w, output kb_report_t res);
    int k;
    int cnt;
    res = '0;
    if (w.op == OP_KEY_EVENT) begin
      live_keys[w.code] = w.down;
      if (sent_keys[w.code] != w.down) begin
        pend_keys[w.code] = w.down;
      end
    end else if (w.is_in && w.room >= MIN_ROOM) begin
      res.report_made = 1'b1;
      for (k = 0; k < 8; k++) begin
        res.modifiers[k] = pend_keys[int'(MOD_FIRST) + k];
      end
      cnt = 0;
      for (k = int'(KEY_FIRST); k <= int'(KEY_LAST); k++) begin
        if (pend_keys[k]) begin
          if (cnt < NUM_SLOTS) begin
            res.slot[cnt] = k[7:0];
          end
          cnt++;
        end
      end
      if (cnt > NUM_SLOTS) begin
        res.slot[NUM_SLOTS-1] = ROLLOVER_CODE;
        res.rollover = 1'b1;
      end
      sent_keys = pend_keys;
      pend_keys = live_keys;
    end
    res.report_pending = (pend_keys != sent_keys);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (rx_quiet || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    int c;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 8'($urandom_range(4, 15));
    end else if (r < 70) begin
      return 8'($urandom_range(224, 231));
    end else if (r < 80) begin
      c = $urandom_range(0, 29);
      if (c < 4) begin
        return 8'(c);
      end else if (c < 6) begin
        return 8'(218 + c);
      end
      return 8'(226 + c);
    end else if (r < 90) begin
      return 8'($urandom_range(200, 221));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic kb_word_t random_word();
    kb_word_t w;
    int r;
    int rr;
    r  = $urandom_range(0, 99);
    rr = $urandom_range(0, 99);
    w.code  = 8'($urandom);
    w.down  = 1'($urandom);
    w.is_in = 1'($urandom);
    w.room  = 16'($urandom);
    if (r < 55) begin
      w.op   = OP_KEY_EVENT;
      w.code = pick_code();
      w.down = ($urandom_range(0, 99) < 55);
    end else if (r < 85) begin
      w.op    = OP_REPORT;
      w.is_in = 1'b1;
      if (rr < 20) begin
        w.room = MIN_ROOM;
      end else if (rr < 30) begin
        w.room = 16'hFFFF;
      end else begin
        w.room = 16'($urandom_range(8, 65535));
      end
    end else begin
      w.op = OP_REPORT;
      if (rr < 40) begin
        w.is_in = 1'b0;
      end else if (rr < 80) begin
        w.is_in = 1'b1;
        w.room  = 16'($urandom_range(0, 7));
      end
    end
    return w;
  endfunction

  function automatic stim_row_t row(input logic op, input logic [7:0] code,
                                    input logic down, input logic is_in,
                                    input logic [15:0] room, input logic lit,
                                    input kb_report_t want);
    stim_row_t t;
    t.stim.op    = op;
    t.stim.code  = code;
    t.stim.down  = down;
    t.stim.is_in = is_in;
    t.stim.room  = room;
    t.lit        = lit;
    t.want       = want;
    return t;
  endfunction

  task automatic send_word(input kb_word_t w, input logic lit, input kb_report_t want,
                           input int gap);
    kb_report_t res;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-26){1'b0}}, w.room, w.is_in, w.down, w.code};
    s_tuser  <= w.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_report(w, res);
    report_q.push_back(lit ? want : res);
  endtask

  task automatic check_report(input kb_report_t want, input kb_report_t seen);
    int k;
    if (seen.report_made !== want.report_made) begin
      $display("%0t report_made expected %h actual %h", $time, want.report_made,
               seen.report_made);
      mismatch_count++;
    end
    if (seen.modifiers !== want.modifiers) begin
      $display("%0t modifiers expected %h actual %h", $time, want.modifiers,
               seen.modifiers);
      mismatch_count++;
    end
    for (k = 0; k < NUM_SLOTS; k++) begin
      if (seen.slot[k] !== want.slot[k]) begin
        $display("%0t key_slot_%0d expected %h actual %h", $time, k + 1, want.slot[k],
                 seen.slot[k]);
        mismatch_count++;
      end
    end
    if (seen.rollover !== want.rollover) begin
      $display("%0t rollover expected %h actual %h", $time, want.rollover, seen.rollover);
      mismatch_count++;
    end
    if (seen.report_pending !== want.report_pending) begin
      $display("%0t report_pending expected %h actual %h", $time, want.report_pending,
               seen.report_pending);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_word.report_made    = m_tuser;
      seen_word.modifiers      = m_tdata[7:0];
      seen_word.slot           = m_tdata[55:8];
      seen_word.rollover       = m_tdata[56];
      seen_word.report_pending = m_tdata[57];
      if (report_q.size() == 0) begin
        $display("%0t unexpected word expected none actual %h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want_word = report_q.pop_front();
        check_report(want_word, seen_word);
      end
    end
  end

  initial begin
    int r;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = HOLD_LONG - 1;
        m_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (rx_quiet || r < 65) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 150);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hid_keyboard_report_builder_core regression: fail");
    $finish;
  end

  initial begin
    stim_row_t  rows[$];
    kb_report_t no_report;
    kb_report_t empty_report;
    int         i;
    no_report                = '0;
    empty_report             = '0;
    empty_report.report_made = 1'b1;
    live_keys      = '0;
    pend_keys      = '0;
    sent_keys      = '0;
    mismatch_count = 0;
    stall_left     = 0;
    long_hold_req  = 1'b0;
    rx_quiet       = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_KEY_EVENT;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    rows.push_back(row(OP_REPORT,    8'hFF, 1'b1, 1'b1, 16'd8,    1'b1, empty_report));
    rows.push_back(row(OP_REPORT,    8'h00, 1'b0, 1'b1, 16'd7,    1'b1, no_report));
    rows.push_back(row(OP_REPORT,    8'hA5, 1'b1, 1'b0, 16'hFFFF, 1'b1, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd4,   1'b1, 1'b0, 16'h0000, 1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd221, 1'b1, 1'b1, 16'hFFFF, 1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd224, 1'b1, 1'b0, 16'h5555, 1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd231, 1'b1, 1'b1, 16'hAAAA, 1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd0,   1'b1, 1'b0, 16'd8,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd255, 1'b1, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd222, 1'b1, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_REPORT,    8'h00, 1'b0, 1'b1, 16'd8,    1'b0, no_report));
    rows.push_back(row(OP_REPORT,    8'h00, 1'b0, 1'b1, 16'hFFFF, 1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd5,   1'b1, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd6,   1'b1, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd7,   1'b1, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd8,   1'b1, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd9,   1'b1, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd10,  1'b1, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd10,  1'b0, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_REPORT,    8'h00, 1'b0, 1'b1, 16'd9,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd4,   1'b0, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_KEY_EVENT, 8'd224, 1'b0, 1'b0, 16'd0,    1'b0, no_report));
    rows.push_back(row(OP_REPORT,    8'h00, 1'b0, 1'b1, 16'hFFFF, 1'b0, no_report));
    rows.push_back(row(OP_REPORT,    8'h00, 1'b0, 1'b0, 16'd8,    1'b0, no_report));
    rows.push_back(row(OP_REPORT,    8'h00, 1'b0, 1'b1, 16'd8,    1'b0, no_report));

    foreach (rows[k]) begin
      send_word(rows[k].stim, rows[k].lit, rows[k].want, pick_gap());
    end

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == 120) begin
        long_hold_req = 1'b1;
      end
      if (i == 250) begin
        s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge clk);
      end
      rx_quiet = (i >= 300 && i < 340);
      send_word(random_word(), 1'b0, no_report, pick_gap());
    end
    s_tvalid <= 1'b0;
    rx_quiet = 1'b0;

    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hid_keyboard_report_builder_core regression: pass");
    end else begin
      $display("hid_keyboard_report_builder_core regression: fail");
    end
    $finish;
  end

endmodule
